// ===== hdl/mh64_pkg.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A engine package
// Shared constants, controller commands and datapath status for the engine.
// ----------------------------------------------------------------------------
package mh64_pkg;

  // Mixing multiplier and shift amount of the hash.
  localparam logic [63:0] MUR_M = 64'hc6a4a7935bd1e995;
  localparam int unsigned MUR_R = 47;

  // Halves of the multiplier for the 32-bit partial products.
  localparam logic [31:0] MUR_M_LO = MUR_M[31:0];
  localparam logic [31:0] MUR_M_HI = MUR_M[63:32];

  // Bytes consumed by one full word.
  localparam logic [31:0] WORD_BYTES = 32'd8;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_START,  // latch length and first word, x = length
    OP_LOAD_WORD,   // latch a continuation word, x = word
    OP_MUL,         // x = x * m over several cycles
    OP_SEED,        // h = seed ^ x, x = latched word
    OP_MIX,         // x ^= x >> r
    OP_FOLD,        // x = h ^ x
    OP_TAIL,        // x = h ^ (low tail bytes of the word)
    OP_STORE,       // h = x, consume one word
    OP_FINAL,       // x = h ^ (h >> r)
    OP_EMIT         // result = x ^ (x >> r)
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;  // no bytes remain
    logic rem_ge8;   // a full word remains
    logic rem_is8;   // exactly one full word remains
    logic mul_done;  // multiplier result is ready this cycle
    logic out_free;  // output register can take a result this cycle
  } stat_t;

endpackage

// ===== hdl/mh64_mul.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A multiplier
// Low 64 bits of a * m, built from three 32x32 partial products that share
// one multiplier.
// ----------------------------------------------------------------------------
module mh64_mul
  import mh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        run,
  input  logic [63:0] a,
  output logic        done,
  output logic [63:0] prod
);

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  logic [1:0]  step_r, step_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] op_a, op_b;
  logic [63:0] pp;

  // Pick the operand halves for the current partial product.
  always_comb begin
    case (step_r)
      STEP_LL: begin
        op_a = a[31:0];
        op_b = MUR_M_LO;
      end
      STEP_LH: begin
        op_a = a[31:0];
        op_b = MUR_M_HI;
      end
      default: begin
        op_a = a[63:32];
        op_b = MUR_M_LO;
      end
    endcase
  end

  assign pp = {32'd0, op_a} * {32'd0, op_b};

  // Accumulate; cross products only reach the upper half.
  always_comb begin
    case (step_r)
      STEP_LL: acc_nxt = pp;
      STEP_LH: acc_nxt = {acc_r[63:32] + pp[31:0], acc_r[31:0]};
      default: acc_nxt = acc_r;
    endcase
  end

  assign prod = {acc_r[63:32] + pp[31:0], acc_r[31:0]};
  assign done = run && (step_r == STEP_HL);

  // Step counter restarts whenever the unit is not running.
  always_comb begin
    if (!run || step_r == STEP_HL) begin
      step_nxt = STEP_LL;
    end else begin
      step_nxt = step_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LL;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

endmodule

// ===== hdl/mh64_dp.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A datapath
// Holds the seed, running hash, work value, byte count and result register,
// and carries out the operations that the controller issues.
// ----------------------------------------------------------------------------
module mh64_dp
  import mh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic [31:0] in_byte_length,
  input  logic [63:0] in_key_word,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata
);

  logic [63:0] seed_r;
  logic [63:0] h_r, h_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] w_r, w_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_data_r, out_data_nxt;
  logic        mul_done;
  logic [63:0] mul_prod;
  logic [63:0] tail_mask;

  mh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .run   (cmd.op == OP_MUL),
    .a     (x_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // Byte mask for the tail bytes that belong to the string.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      tail_mask[8*i +: 8] = (rem_r[2:0] > i[2:0]) ? 8'hff : 8'h00;
    end
  end

  // Operation decode.
  always_comb begin
    h_nxt         = h_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    rem_nxt       = rem_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (cmd.op)
      OP_LOAD_START: begin
        x_nxt   = {32'd0, in_byte_length};
        w_nxt   = in_key_word;
        rem_nxt = in_byte_length;
      end
      OP_LOAD_WORD: begin
        x_nxt = in_key_word;
        w_nxt = in_key_word;
      end
      OP_MUL: begin
        if (mul_done) begin
          x_nxt = mul_prod;
        end
      end
      OP_SEED: begin
        h_nxt = seed_r ^ x_r;
        x_nxt = w_r;
      end
      OP_MIX:   x_nxt = x_r ^ (x_r >> MUR_R);
      OP_FOLD:  x_nxt = h_r ^ x_r;
      OP_TAIL:  x_nxt = h_r ^ (w_r & tail_mask);
      OP_STORE: begin
        h_nxt   = x_r;
        rem_nxt = rem_r - WORD_BYTES;
      end
      OP_FINAL: x_nxt = h_r ^ (h_r >> MUR_R);
      OP_EMIT: begin
        out_data_nxt  = x_r ^ (x_r >> MUR_R);
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Status back to the controller.
  always_comb begin
    stat.rem_zero = (rem_r == 32'd0);
    stat.rem_ge8  = (rem_r[31:3] != 29'd0);
    stat.rem_is8  = (rem_r == WORD_BYTES);
    stat.mul_done = mul_done;
    stat.out_free = !out_valid_r || out_tready;
  end

  // Control registers and the seed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= 64'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed_r <= cfg_wdata;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    x_r        <= x_nxt;
    w_r        <= w_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/mh64_ctrl.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A controller
// Sequences the datapath through seeding, word mixing, tail handling and
// finalization, and accepts items only between strings or between words.
// ----------------------------------------------------------------------------
module mh64_ctrl
  import mh64_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  logic  in_start,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAIT_WORD,
    ST_MUL_LEN,
    ST_SEED,
    ST_MUL_K1,
    ST_MIX,
    ST_MUL_K2,
    ST_FOLD,
    ST_MUL_H,
    ST_TAIL,
    ST_STORE,
    ST_FINAL,
    ST_MUL_F,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) || (state_r == ST_WAIT_WORD);
  assign accept    = in_tvalid && in_tready;

  // Next state and command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    case (state_r)
      ST_IDLE, ST_WAIT_WORD: begin
        if (accept && in_start) begin
          cmd.op    = OP_LOAD_START;
          state_nxt = ST_MUL_LEN;
        end else if (accept && state_r == ST_WAIT_WORD) begin
          cmd.op    = OP_LOAD_WORD;
          state_nxt = stat.rem_ge8 ? ST_MUL_K1 : ST_TAIL;
        end
      end
      ST_MUL_LEN: begin
        cmd.op = OP_MUL;
        if (stat.mul_done) begin
          state_nxt = ST_SEED;
        end
      end
      ST_SEED: begin
        cmd.op = OP_SEED;
        if (stat.rem_zero) begin
          state_nxt = ST_FINAL;
        end else if (stat.rem_ge8) begin
          state_nxt = ST_MUL_K1;
        end else begin
          state_nxt = ST_TAIL;
        end
      end
      ST_MUL_K1: begin
        cmd.op = OP_MUL;
        if (stat.mul_done) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd.op    = OP_MIX;
        state_nxt = ST_MUL_K2;
      end
      ST_MUL_K2: begin
        cmd.op = OP_MUL;
        if (stat.mul_done) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.op    = OP_FOLD;
        state_nxt = ST_MUL_H;
      end
      ST_TAIL: begin
        cmd.op    = OP_TAIL;
        state_nxt = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd.op = OP_MUL;
        if (stat.mul_done) begin
          state_nxt = ST_STORE;
        end
      end
      // A tail word or the last full word ends the string.
      ST_STORE: begin
        cmd.op = OP_STORE;
        if (!stat.rem_ge8 || stat.rem_is8) begin
          state_nxt = ST_FINAL;
        end else begin
          state_nxt = ST_WAIT_WORD;
        end
      end
      ST_FINAL: begin
        cmd.op    = OP_FINAL;
        state_nxt = ST_MUL_F;
      end
      ST_MUL_F: begin
        cmd.op = OP_MUL;
        if (stat.mul_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hdl/murmur64a_string_hash_top.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A string hash engine
// Hashes a byte string delivered as little-endian 64-bit words and returns
// the 64-bit digest.
// ----------------------------------------------------------------------------
// A string starts with an item whose in_tuser is 1; it carries the total byte
// length and the first word. Further words follow with in_tuser 0, and one
// digest comes out after the word that completes the string. The seed is to
// be written through cfg_we/cfg_wdata only while the engine is idle; the
// engine does not enforce this. All products share one 32x32 multiplier. A
// full word, once accepted, passes MUL_K1, MIX, MUL_K2, FOLD, MUL_H and STORE
// before the next continuation word is taken. A start item seeds through
// MUL_LEN and SEED, a tail word passes TAIL, MUL_H and STORE, and finalization
// steps through FINAL and MUL_F before the digest enters the output register;
// that last step also waits while the output register still holds an earlier
// digest. A start item during a string drops that string. The next item can be
// taken while a digest still waits on the output.
// ----------------------------------------------------------------------------
module murmur64a_string_hash_top
  import mh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,   // hash_seed
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,    // [31:0] byte_length, [95:32] key_word
  input  logic        in_tuser,    // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata    // [63:0] hash_value
);

  cmd_t  cmd;
  stat_t stat;

  mh64_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_start  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  mh64_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_byte_length (in_tdata[31:0]),
    .in_key_word    (in_tdata[95:32]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata)
  );

endmodule

// ===== tb/murmur64a_string_hash_checker.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A engine digest checker
// Watches the seed port and both streams of the hash engine. It keeps its own
// hash state, works out the digest for every accepted item that completes a
// string, and compares each digest leaving the engine with the oldest one
// still waiting.
// ----------------------------------------------------------------------------
module murmur64a_string_hash_checker
  import mh64_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [95:0] in_tdata,          // [31:0] byte_length, [95:32] key_word
  input  logic        in_tuser,          // [0] start_req
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,         // [63:0] hash_value
  input  logic        run_done,
  output int          mismatch_count,
  output int          digests_pending
);

  // Shadow copy of the engine state.
  logic [63:0] seed_reg;
  logic [63:0] hash_acc;
  logic [31:0] bytes_left;
  logic        string_open;

  logic [63:0] expected_digests[$];
  int          error_total;
  logic        end_seen;

  // One full word through the multiply, shift-xor, multiply mix.
  function automatic logic [63:0] scramble_word(input logic [63:0] word);
    logic [63:0] k;
    k = word * MUR_M;
    k = k ^ (k >> MUR_R);
    k = k * MUR_M;
    return k;
  endfunction

  // Final avalanche applied before a digest leaves the engine.
  function automatic logic [63:0] finalize_hash(input logic [63:0] h);
    logic [63:0] f;
    f = h ^ (h >> MUR_R);
    f = f * MUR_M;
    f = f ^ (f >> MUR_R);
    return f;
  endfunction

  // Advances the shadow state by one accepted item and reports the digest
  // when the item completes a string.
  task automatic absorb_string_item(input logic start, input logic [31:0] len,
                                    input logic [63:0] word, output logic produced,
                                    output logic [63:0] digest);
    logic [63:0] tail_mask;
    produced = 1'b0;
    digest = '0;
    if (start) begin
      // A start drops any unfinished string and seeds a new one.
      hash_acc = seed_reg ^ ({32'd0, len} * MUR_M);
      bytes_left = len;
      string_open = 1'b0;
      if (len == 32'd0) begin
        digest = finalize_hash(hash_acc);
        hash_acc = '0;
        produced = 1'b1;
        return;
      end
      string_open = 1'b1;
    end else if (!string_open) begin
      // A continuation word with no string open is dropped.
      return;
    end
    if (bytes_left >= 32'd8) begin
      hash_acc = (hash_acc ^ scramble_word(word)) * MUR_M;
      bytes_left = bytes_left - 32'd8;
      if (bytes_left != 32'd0) return;
      digest = finalize_hash(hash_acc);
    end else begin
      // Only the low tail bytes belong to the string.
      tail_mask = (64'd1 << (8 * bytes_left[2:0])) - 64'd1;
      digest = finalize_hash((hash_acc ^ (word & tail_mask)) * MUR_M);
    end
    hash_acc = '0;
    bytes_left = '0;
    string_open = 1'b0;
    produced = 1'b1;
  endtask

  // Prediction and comparison, all on the rising edge.
  always @(posedge clk) begin : scoreboard
    logic        got_digest;
    logic [63:0] new_digest;
    logic [63:0] oldest;
    if (!rst_n) begin
      seed_reg = '0;
      hash_acc = '0;
      bytes_left = '0;
      string_open = 1'b0;
      expected_digests.delete();
      error_total = 0;
      end_seen = 1'b0;
    end else begin
      if (cfg_we) begin
        seed_reg = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        absorb_string_item(in_tuser, in_tdata[31:0], in_tdata[95:32], got_digest,
                           new_digest);
        if (got_digest) expected_digests.push_back(new_digest);
      end
      if (out_tvalid && out_tready) begin
        if (expected_digests.size() == 0) begin
          $error("hash_value: expected no digest, got %h", out_tdata);
          error_total++;
        end else begin
          oldest = expected_digests.pop_front();
          if (out_tdata !== oldest) begin
            $error("hash_value: expected %h, got %h", oldest, out_tdata);
            error_total++;
          end
        end
      end
      // Anything still waiting at the end of the run is a missing digest.
      if (run_done && !end_seen) begin
        end_seen = 1'b1;
        if (expected_digests.size() != 0) begin
          $error("hash_value: expected %h and %0d more, got nothing",
                 expected_digests[0], expected_digests.size() - 1);
          error_total += expected_digests.size();
        end
      end
    end
    mismatch_count <= error_total;
    digests_pending <= expected_digests.size();
  end

endmodule

// ===== tb/murmur64a_string_hash_top_tb.sv =====
// ----------------------------------------------------------------------------
// MurmurHash64A string hash engine testbench
// Sends directed and random strings through the engine under several seeds
// and several patterns of sender gaps and receiver stalls. A checker module
// beside the engine predicts every digest and compares it with the output.
// ----------------------------------------------------------------------------
module murmur64a_string_hash_top_tb;

  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_ITEMS = 375;
  localparam int LONG_HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;          // [31:0] byte_length, [95:32] key_word
  logic        in_tuser = 1'b0;        // [0] start_req
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;              // [63:0] hash_value

  logic run_done = 1'b0;
  int   mismatch_count;
  int   digests_pending;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int items_sent = 0;
  int cycle_count = 0;

  murmur64a_string_hash_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  murmur64a_string_hash_checker digest_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .run_done        (run_done),
    .mismatch_count  (mismatch_count),
    .digests_pending (digests_pending)
  );

  always #5 clk = ~clk;

  // Run limit in case the engine hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("murmur64a_string_hash_top_tb: errors");
      $finish;
    end
  end

  // Digest receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Key words lean toward all zeros and all ones now and then.
  function automatic logic [63:0] random_word();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short strings, a few long ones.
  function automatic int unsigned random_length();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 65) return $urandom_range(40);
    if (pick < 95) return $urandom_range(200, 41);
    return $urandom_range(1000, 201);
  endfunction

  // Offers one item, with a random gap in front of it, and returns at the
  // rising edge that accepts it.
  task automatic offer_item(input logic start, input logic [31:0] len,
                            input logic [63:0] word);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= start;
    in_tdata <= {word, len};
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // A whole string: a start item with the length, then the remaining words.
  task automatic send_string(input int unsigned len);
    int unsigned words;
    words = (len + 7) / 8;
    offer_item(1'b1, len, random_word());
    items_sent++;
    for (int unsigned w = 1; w < words; w++) begin
      offer_item(1'b0, $urandom(), random_word());
      items_sent++;
    end
  endtask

  // A string cut short; the next start drops it.
  task automatic send_cut_string();
    logic [31:0] len;
    int unsigned words;
    int unsigned sent;
    len = ($urandom_range(1)) ? $urandom() : $urandom_range(100, 16);
    if (len < 32'd16) len = len + 32'd16;
    words = (len > 32'd800) ? 100 : (len + 7) / 8;
    sent = $urandom_range(3, 1);
    if (sent > words - 1) sent = words - 1;
    offer_item(1'b1, len, random_word());
    items_sent++;
    for (int unsigned w = 1; w < sent; w++) begin
      offer_item(1'b0, $urandom(), random_word());
      items_sent++;
    end
  endtask

  // Stops sending and waits until every digest is out and the engine is idle.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (digests_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_seed(input logic [63:0] seed);
    cfg_we <= 1'b1;
    cfg_wdata <= seed;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Main stimulus.
  initial begin : stimulus
    logic [63:0]  phase_seed[4];
    int           phase_start;
    int unsigned  pick;
    phase_seed = '{64'hffff_ffff_ffff_ffff, {$urandom(), $urandom()}, 64'd0,
                   {$urandom(), $urandom()}};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings under the reset seed.
    // Empty string: the key word is ignored.
    offer_item(1'b1, 32'd0, '1);
    // Single full words at both extremes.
    offer_item(1'b1, 32'd8, '0);
    offer_item(1'b1, 32'd8, '1);
    // Short tails: the bytes above the tail must not matter.
    offer_item(1'b1, 32'd1, '1);
    offer_item(1'b1, 32'd7, '1);
    offer_item(1'b1, 32'd7, 64'h8000_0000_0000_0000);
    // Two full words, then a full word plus a tail.
    offer_item(1'b1, 32'd16, 64'h0123_4567_89ab_cdef);
    offer_item(1'b0, 32'hffff_ffff, 64'hfedc_ba98_7654_3210);
    offer_item(1'b1, 32'd15, '1);
    offer_item(1'b0, 32'd0, '1);
    // A word with no string open is dropped.
    offer_item(1'b0, 32'hffff_ffff, '1);
    // Longest length, cut short by a new start.
    offer_item(1'b1, 32'hffff_ffff, '1);
    offer_item(1'b0, 32'd0, '1);
    offer_item(1'b1, 32'd3, 64'h0011_2233_4455_6677);
    // A string dropped by an empty string.
    offer_item(1'b1, 32'd24, random_word());
    offer_item(1'b0, 32'd5, random_word());
    offer_item(1'b1, 32'd0, random_word());
    offer_item(1'b1, 32'd9, '1);
    offer_item(1'b0, 32'd0, '1);
    wait_drained();

    // Random phases, each under its own seed and handshake pattern.
    for (int phase = 0; phase < 4; phase++) begin
      load_seed(phase_seed[phase]);
      case (phase)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
          hold_requests <= hold_requests + 1;
        end
        1: begin
          tx_idle_pct = 72;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 72;
        end
        default: begin
          tx_idle_pct = 14;
          rx_stall_pct <= 14;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          send_cut_string();
        end else begin
          send_string(random_length());
          if (pick >= 92) offer_item(1'b0, $urandom(), random_word());
        end
      end
      // Close the phase on a complete string so the engine ends idle.
      send_string(random_length());
      wait_drained();
    end

    run_done <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (mismatch_count == 0) begin
      $display("murmur64a_string_hash_top_tb: clean");
    end else begin
      $display("murmur64a_string_hash_top_tb: errors");
    end
    $finish;
  end

endmodule
